FILE: rtl/core/baro_sensor_compensation_unit_macros.svh
// Assertion macros shared by the compensation unit and its divider.
// Both expect the clock aclk and the active-low reset aresetn in scope.
`ifndef BARO_SENSOR_COMPENSATION_UNIT_MACROS_SVH
`define BARO_SENSOR_COMPENSATION_UNIT_MACROS_SVH
`ifndef SYNTH
`define BSCU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define BSCU_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) pre |=> post) else $error(msg);
`else
`define BSCU_ASSERT(lbl, prop, msg)
`define BSCU_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

FILE: rtl/core/bscu_pkg.sv
package bscu_pkg;

    // Configuration register indexes.
    localparam logic [1:0] CFG_TEMP_COEFFS = 2'd0;
    localparam logic [1:0] CFG_PRESS_LOW   = 2'd1;
    localparam logic [1:0] CFG_PRESS_HIGH  = 2'd2;

    // Divider geometry: numerator magnitude, divisor magnitude, quotient bits.
    localparam int DivStages = 38;
    localparam int NumW      = 71;
    localparam int DenW      = 35;

    // Bias of the pressure divisor polynomial, 2^47.
    localparam logic signed [50:0] Var1Bias = 51'sd1 <<< 47;

    // Quotient saturation level, 2^36.
    localparam logic [DivStages-1:0] QuotLim = 38'h10_0000_0000;

    typedef struct packed {
        logic signed [14:0] temp;
        logic signed [19:0] tf;
        logic               fault;
        logic               neg;
        logic               ovf;
    } side_t;

endpackage

FILE: rtl/core/baro_sensor_compensation_unit.sv
// Barometric sensor compensation unit.
// Input stream s_*: one beat carries the six raw result bytes of one sample
// (temperature msb/lsb/xlsb, then pressure msb/lsb/xlsb, byte 0 lowest).
// Output stream m_*: one beat per input beat, in order, with the temperature
// in 0.01 degC, the fine temperature term and the pressure in Q17.8 pascals;
// m_tuser flags a zero pressure divisor, in which case the pressure is 0.
// Calibration words are loaded through cfg_wr_* by the user, who must do so only while
// the stream is idle; the block itself does not enforce it. Throughput is one sample
// per cycle while the skid entry is empty. From the accepting edge to m_tvalid a sample
// passes nine arithmetic stages, a 38-stage restoring divider that retires one quotient
// bit per stage, four correction stages and the output register.
// Reset clears the coefficients to zero and empties the pipeline.
// When the receiver stalls, the result waits in the output register and one
// more beat goes into a skid entry; the pipeline freezes only while the skid
// entry is full, so no beat is lost or repeated.
`include "baro_sensor_compensation_unit_macros.svh"

module baro_sensor_compensation_unit (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // raw temperature msb, lsb, xlsb bytes, then raw pressure msb, lsb, xlsb bytes
    input  logic [47:0] s_tdata,
    output logic        m_tvalid,
    input  logic        m_tready,
    // temperature_centi[14:0], fine_temperature[34:15], pressure_q17_8[59:35], zero pad
    output logic [63:0] m_tdata,
    // divide_fault
    output logic        m_tuser,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_wr_index,
    input  logic [63:0] cfg_wr_data
);
    import bscu_pkg::*;

    typedef struct packed {
        logic [24:0]        press;
        logic signed [19:0] tf;
        logic signed [14:0] temp;
        logic               fault;
    } res_t;

    logic [63:0] temp_coeffs_reg, press_low_reg, press_high_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_coeffs_reg <= '0;
            press_low_reg   <= '0;
            press_high_reg  <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                CFG_TEMP_COEFFS: temp_coeffs_reg <= cfg_wr_data;
                CFG_PRESS_LOW:   press_low_reg   <= cfg_wr_data;
                CFG_PRESS_HIGH:  press_high_reg  <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    logic [15:0]        t1, p1;
    logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;

    assign t1 = temp_coeffs_reg[15:0];
    assign t2 = $signed(temp_coeffs_reg[31:16]);
    assign t3 = $signed(temp_coeffs_reg[47:32]);
    assign p1 = temp_coeffs_reg[63:48];
    assign p2 = $signed(press_low_reg[15:0]);
    assign p3 = $signed(press_low_reg[31:16]);
    assign p4 = $signed(press_low_reg[47:32]);
    assign p5 = $signed(press_low_reg[63:48]);
    assign p6 = $signed(press_high_reg[15:0]);
    assign p7 = $signed(press_high_reg[31:16]);
    assign p8 = $signed(press_high_reg[47:32]);
    assign p9 = $signed(press_high_reg[63:48]);

    logic en, push;
    logic skid_v_reg, m_v_reg;
    res_t skid_reg, m_data_reg, p4_res;

    assign en       = !skid_v_reg;
    assign s_tready = en;

    // Stage 1: assemble raw readings, first temperature products.
    logic [19:0]        adc_t, adc_p;
    logic signed [17:0] s1_diff;
    logic signed [16:0] s1_d;
    logic               v1_reg;
    logic signed [33:0] c1_pa_reg, c1_dd_reg;
    logic [19:0]        c1_adcp_reg;

    assign adc_t   = {s_tdata[7:0], s_tdata[15:8], s_tdata[23:20]};
    assign adc_p   = {s_tdata[31:24], s_tdata[39:32], s_tdata[47:44]};
    assign s1_diff = $signed({1'b0, adc_t[19:3]}) - $signed({1'b0, t1, 1'b0});
    assign s1_d    = $signed({1'b0, adc_t[19:4]}) - $signed({1'b0, t1});

    // Stage 2: temperature terms summed.
    logic signed [21:0] s2_ddh;
    logic signed [37:0] s2_b;
    logic signed [24:0] s2_tf;
    logic               v2_reg;
    logic signed [24:0] c2_tf_reg;
    logic [19:0]        c2_adcp_reg;

    assign s2_ddh = $signed(c1_dd_reg[33:12]);
    assign s2_b   = s2_ddh * t3;
    assign s2_tf  = $signed(c1_pa_reg[33:11]) + $signed(s2_b[37:14]);

    // Stage 3: clamp fine term, temperature, pressure offset.
    logic signed [19:0] s3_tf;
    logic signed [23:0] s3_t5;
    logic signed [15:0] s3_tsh;
    logic signed [14:0] s3_temp;
    logic signed [20:0] s3_pa;
    logic               v3_reg;
    logic signed [19:0] c3_tf_reg;
    logic signed [14:0] c3_temp_reg;
    logic signed [20:0] c3_pa_reg;
    logic [19:0]        c3_adcp_reg;

    always_comb begin
        if (c2_tf_reg < -25'sd524288) begin
            s3_tf = -20'sd524288;
        end else if (c2_tf_reg > 25'sd524287) begin
            s3_tf = 20'sd524287;
        end else begin
            s3_tf = c2_tf_reg[19:0];
        end
    end

    assign s3_t5  = $signed({s3_tf, 2'b00}) + s3_tf + 24'sd128;
    assign s3_tsh = s3_t5[23:8];

    always_comb begin
        if (s3_tsh < -16'sd4000) begin
            s3_temp = -15'sd4000;
        end else if (s3_tsh > 16'sd8500) begin
            s3_temp = 15'sd8500;
        end else begin
            s3_temp = s3_tsh[14:0];
        end
    end

    assign s3_pa = s3_tf - 21'sd128000;

    // Stage 4: products of the pressure offset.
    logic               v4_reg;
    logic signed [41:0] c4_aa_reg;
    logic signed [36:0] c4_ap5_reg, c4_ap2_reg;
    logic signed [19:0] c4_tf_reg;
    logic signed [14:0] c4_temp_reg;
    logic [19:0]        c4_adcp_reg;

    // Stage 5: square terms times P6 and P3.
    logic               v5_reg;
    logic signed [57:0] c5_b6_reg, c5_a3_reg;
    logic signed [36:0] c5_ap5_reg, c5_ap2_reg;
    logic signed [19:0] c5_tf_reg;
    logic signed [14:0] c5_temp_reg;
    logic [19:0]        c5_adcp_reg;

    // Stage 6: numerator offset and divisor polynomial sums.
    logic               v6_reg;
    logic signed [57:0] c6_bsum_reg;
    logic signed [50:0] c6_asum_reg;
    logic signed [19:0] c6_tf_reg;
    logic signed [14:0] c6_temp_reg;
    logic [19:0]        c6_adcp_reg;

    // Stage 7: divisor times P1, numerator.
    logic signed [21:0] s7_pr;
    logic               v7_reg;
    logic signed [67:0] c7_vprod_reg;
    logic signed [58:0] c7_m_reg;
    logic signed [19:0] c7_tf_reg;
    logic signed [14:0] c7_temp_reg;

    assign s7_pr = 22'sd1048576 - $signed({2'b00, c6_adcp_reg});

    // Stage 8: divisor scaled down, numerator times 3125.
    logic               v8_reg;
    logic signed [34:0] c8_var1_reg;
    logic signed [71:0] c8_n3_reg;
    logic signed [19:0] c8_tf_reg;
    logic signed [14:0] c8_temp_reg;

    // Stage 9: signs and magnitudes for the divider.
    logic signed [71:0] s9_nneg;
    logic signed [34:0] s9_dneg;
    logic [NumW-1:0]    s9_nmag;
    logic [DenW-1:0]    s9_dmag;
    logic               v9_reg;
    logic [NumW-1:0]    c9_nmag_reg;
    logic [DenW-1:0]    c9_dmag_reg;
    side_t              c9_side_reg;

    assign s9_nneg = -c8_n3_reg;
    assign s9_dneg = -c8_var1_reg;
    assign s9_nmag = c8_n3_reg[71] ? s9_nneg[NumW-1:0] : c8_n3_reg[NumW-1:0];
    assign s9_dmag = c8_var1_reg[34] ? s9_dneg : c8_var1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            {v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg, v9_reg} <= '0;
        end else if (en) begin
            v1_reg <= s_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
            v6_reg <= v5_reg;
            v7_reg <= v6_reg;
            v8_reg <= v7_reg;
            v9_reg <= v8_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            c1_pa_reg   <= s1_diff * t2;
            c1_dd_reg   <= s1_d * s1_d;
            c1_adcp_reg <= adc_p;

            c2_tf_reg   <= s2_tf;
            c2_adcp_reg <= c1_adcp_reg;

            c3_tf_reg   <= s3_tf;
            c3_temp_reg <= s3_temp;
            c3_pa_reg   <= s3_pa;
            c3_adcp_reg <= c2_adcp_reg;

            c4_aa_reg   <= c3_pa_reg * c3_pa_reg;
            c4_ap5_reg  <= c3_pa_reg * p5;
            c4_ap2_reg  <= c3_pa_reg * p2;
            c4_tf_reg   <= c3_tf_reg;
            c4_temp_reg <= c3_temp_reg;
            c4_adcp_reg <= c3_adcp_reg;

            c5_b6_reg   <= c4_aa_reg * p6;
            c5_a3_reg   <= c4_aa_reg * p3;
            c5_ap5_reg  <= c4_ap5_reg;
            c5_ap2_reg  <= c4_ap2_reg;
            c5_tf_reg   <= c4_tf_reg;
            c5_temp_reg <= c4_temp_reg;
            c5_adcp_reg <= c4_adcp_reg;

            c6_bsum_reg <= c5_b6_reg + $signed({c5_ap5_reg, 17'b0}) + $signed({p4, 35'b0});
            c6_asum_reg <= $signed(c5_a3_reg[57:8]) + $signed({c5_ap2_reg, 12'b0}) + Var1Bias;
            c6_tf_reg   <= c5_tf_reg;
            c6_temp_reg <= c5_temp_reg;
            c6_adcp_reg <= c5_adcp_reg;

            c7_vprod_reg <= c6_asum_reg * $signed({1'b0, p1});
            c7_m_reg     <= $signed({s7_pr, 31'b0}) - c6_bsum_reg;
            c7_tf_reg    <= c6_tf_reg;
            c7_temp_reg  <= c6_temp_reg;

            c8_var1_reg <= c7_vprod_reg[67:33];
            c8_n3_reg   <= c7_m_reg * 13'sd3125;
            c8_tf_reg   <= c7_tf_reg;
            c8_temp_reg <= c7_temp_reg;

            c9_nmag_reg       <= s9_nmag;
            c9_dmag_reg       <= s9_dmag;
            c9_side_reg.temp  <= c8_temp_reg;
            c9_side_reg.tf    <= c8_tf_reg;
            c9_side_reg.fault <= (c8_var1_reg == 35'sd0);
            c9_side_reg.neg   <= c8_n3_reg[71] ^ c8_var1_reg[34];
            // A quotient of 2^38 or more saturates regardless of its low bits.
            c9_side_reg.ovf   <= {{(DenW-(NumW-DivStages)){1'b0}}, s9_nmag[NumW-1:DivStages]}
                                 >= s9_dmag;
        end
    end

    logic                 div_v;
    logic [DivStages-1:0] div_q;
    side_t                div_side;

    bscu_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (v9_reg),
        .in_nmag   (c9_nmag_reg),
        .in_dmag   (c9_dmag_reg),
        .in_side   (c9_side_reg),
        .out_valid (div_v),
        .out_quot  (div_q),
        .out_side  (div_side)
    );

    // P1: saturate and sign the quotient.
    logic [DivStages-1:0]        q1_mag;
    logic signed [DivStages-1:0] q1_p;
    logic                        vp1_reg, vp2_reg, vp3_reg, vp4_reg;
    logic signed [37:0]          cp1_p_reg, cp2_p_reg, cp3_p_reg;
    side_t                       cp1_side_reg, cp2_side_reg, cp3_side_reg;
    logic signed [49:0]          cp2_ss_reg;
    logic signed [53:0]          cp2_b8_reg, cp3_b8_reg;
    logic signed [65:0]          cp3_a9_reg;
    res_t                        cp4_res_reg;

    assign q1_mag = (div_side.ovf || div_q > QuotLim) ? QuotLim : div_q;
    assign q1_p   = div_side.neg ? -$signed(q1_mag) : $signed(q1_mag);

    // P4: final correction and clamp.
    logic signed [24:0] p2_s;
    logic signed [41:0] p4_sum;
    logic signed [33:0] p4_q;
    logic signed [34:0] p4_pr;
    logic [24:0]        p4_press;

    assign p2_s   = cp1_p_reg[37:13];
    assign p4_sum = cp3_p_reg + $signed(cp3_a9_reg[65:25]) + $signed(cp3_b8_reg[53:19]);
    assign p4_q   = p4_sum[41:8];
    assign p4_pr  = p4_q + $signed({p7, 4'b0});

    always_comb begin
        if (cp3_side_reg.fault || p4_pr < 35'sd0) begin
            p4_press = '0;
        end else if (p4_pr > 35'sd33554431) begin
            p4_press = '1;
        end else begin
            p4_press = p4_pr[24:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            {vp1_reg, vp2_reg, vp3_reg, vp4_reg} <= '0;
        end else if (en) begin
            vp1_reg <= div_v;
            vp2_reg <= vp1_reg;
            vp3_reg <= vp2_reg;
            vp4_reg <= vp3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cp1_p_reg    <= q1_p;
            cp1_side_reg <= div_side;

            cp2_ss_reg   <= p2_s * p2_s;
            cp2_b8_reg   <= cp1_p_reg * p8;
            cp2_p_reg    <= cp1_p_reg;
            cp2_side_reg <= cp1_side_reg;

            cp3_a9_reg   <= cp2_ss_reg * p9;
            cp3_b8_reg   <= cp2_b8_reg;
            cp3_p_reg    <= cp2_p_reg;
            cp3_side_reg <= cp2_side_reg;

            cp4_res_reg.press <= p4_press;
            cp4_res_reg.tf    <= cp3_side_reg.tf;
            cp4_res_reg.temp  <= cp3_side_reg.temp;
            cp4_res_reg.fault <= cp3_side_reg.fault;
        end
    end

    // Output register with one skid entry behind it.
    assign p4_res = cp4_res_reg;
    assign push   = en && vp4_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_v_reg    <= 1'b0;
            skid_v_reg <= 1'b0;
        end else if (m_tready || !m_v_reg) begin
            m_v_reg    <= skid_v_reg || push;
            skid_v_reg <= 1'b0;
        end else if (push) begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (m_tready || !m_v_reg) begin
            m_data_reg <= skid_v_reg ? skid_reg : p4_res;
        end else if (push) begin
            skid_reg <= p4_res;
        end
    end

    assign m_tvalid = m_v_reg;
    assign m_tdata  = {4'b0000, m_data_reg.press, m_data_reg.tf, m_data_reg.temp};
    assign m_tuser  = m_data_reg.fault;

    `BSCU_ASSERT(a_skid_behind_out, skid_v_reg |-> m_v_reg, "skid entry full with output empty")
    `BSCU_ASSERT_NEXT(a_skid_holds, skid_v_reg && !m_tready, skid_v_reg, "skid entry dropped while stalled")
    `BSCU_ASSERT(a_fault_zero, m_tvalid && m_tuser |-> m_tdata[59:35] == 25'd0, "fault beat with nonzero pressure")
    `BSCU_ASSERT(a_temp_range, m_tvalid |-> $signed(m_tdata[14:0]) >= -15'sd4000 && $signed(m_tdata[14:0]) <= 15'sd8500, "temperature outside range")

endmodule

FILE: rtl/core/bscu_div.sv
`include "baro_sensor_compensation_unit_macros.svh"

module bscu_div (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic [bscu_pkg::NumW-1:0]           in_nmag,
    input  logic [bscu_pkg::DenW-1:0]           in_dmag,
    input  bscu_pkg::side_t                     in_side,
    output logic                                out_valid,
    output logic [bscu_pkg::DivStages-1:0]      out_quot,
    output bscu_pkg::side_t                     out_side
);
    import bscu_pkg::*;

    logic [DivStages-1:0] vld_reg;
    logic [DenW-1:0]      rem_reg  [DivStages];
    logic [DivStages-1:0] nq_reg   [DivStages];
    logic [DenW-1:0]      den_reg  [DivStages];
    side_t                side_reg [DivStages];

    logic [DivStages-1:0] vin;
    logic [DenW-1:0]      rin  [DivStages];
    logic [DivStages-1:0] nin  [DivStages];
    logic [DenW-1:0]      din  [DivStages];
    side_t                sin  [DivStages];

    // Each stage retires one quotient bit. nq holds the numerator bits still
    // to come at the top and the quotient bits found so far at the bottom.
    for (genvar k = 0; k < DivStages; k++) begin : g_stage
        logic [DenW:0]   tr;
        logic            ge;
        logic [DenW:0]   diff;

        if (k == 0) begin : g_first
            assign vin[k] = in_valid;
            assign rin[k] = {{(DenW-(NumW-DivStages)){1'b0}}, in_nmag[NumW-1:DivStages]};
            assign nin[k] = in_nmag[DivStages-1:0];
            assign din[k] = in_dmag;
            assign sin[k] = in_side;
        end else begin : g_next
            assign vin[k] = vld_reg[k-1];
            assign rin[k] = rem_reg[k-1];
            assign nin[k] = nq_reg[k-1];
            assign din[k] = den_reg[k-1];
            assign sin[k] = side_reg[k-1];
        end

        assign tr   = {rin[k], nin[k][DivStages-1]};
        assign ge   = tr >= {1'b0, din[k]};
        assign diff = tr - {1'b0, din[k]};

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vld_reg[k] <= 1'b0;
            end else if (en) begin
                vld_reg[k] <= vin[k];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= ge ? diff[DenW-1:0] : tr[DenW-1:0];
                nq_reg[k]   <= {nin[k][DivStages-2:0], ge};
                den_reg[k]  <= din[k];
                side_reg[k] <= sin[k];
            end
        end
    end

    assign out_valid = vld_reg[DivStages-1];
    assign out_quot  = nq_reg[DivStages-1];
    assign out_side  = side_reg[DivStages-1];

    `BSCU_ASSERT(a_rem_below_den, out_valid && !out_side.fault && !out_side.ovf |-> rem_reg[DivStages-1] < den_reg[DivStages-1], "divider remainder not below divisor")
    `BSCU_ASSERT_NEXT(a_hold_on_stall, !en, $stable(vld_reg), "divider moved while stalled")
    `BSCU_ASSERT_NEXT(a_enter, in_valid && en, vld_reg[0], "divider lost an entering beat")

endmodule
